FILE: rtl/sce_pkg.sv
package sce_pkg;

    localparam int ENERGY_W = 8;
    localparam int COST_W   = 16;
    localparam int WIDTH_W  = 11;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;
    localparam logic [COST_W-1:0]  COST_SAT          = 16'hFFFF;

endpackage

FILE: rtl/sce_energy_if.sv
interface sce_energy_if;
    logic                         valid;
    logic                         ready;
    logic [sce_pkg::ENERGY_W-1:0] energy_value;
    logic                         frame_start;

    modport source (output valid, output energy_value, output frame_start, input ready);
    modport sink   (input valid, input energy_value, input frame_start, output ready);
endinterface

FILE: rtl/sce_cost_if.sv
interface sce_cost_if;
    logic                       valid;
    logic                       ready;
    logic [sce_pkg::COST_W-1:0] path_cost;
    logic                       row_end;

    modport source (output valid, output path_cost, output row_end, input ready);
    modport sink   (input valid, input path_cost, input row_end, output ready);
endinterface

FILE: rtl/seam_cumulative_energy_unit.sv
// Channel      Dir   Payload                        Handshake
// i_pix        in    energy_value[7:0], frame_start valid / ready
// o_cost       out   path_cost[15:0], row_end       valid / ready
// i_cfg_wr_*   in    image_width[10:0]              write enable only
//
// One item per cycle sustained unless o_cost stalls.
// The line buffer is read (current and right-hand column) at accept, and the
// cost is written back when the item leaves the compute stage; a same-cycle
// write to a read address is forwarded into the read register.
// Reset (synchronous, active low) empties the pipeline, sets the width to 1024
// and starts a first row at column 0. The line buffer is not cleared.
// A stalled o_cost holds the compute stage; i_pix.ready drops only when both
// the compute stage and the output register are full and o_cost.ready is low.
module seam_cumulative_energy_unit #(
    parameter int MAX_WIDTH = sce_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [sce_pkg::WIDTH_W-1:0] i_cfg_wr_data,
    sce_energy_if.sink                  i_pix,
    sce_cost_if.source                  o_cost
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > sce_pkg::WIDTH_W) ? CW + 1 : sce_pkg::WIDTH_W;
    localparam logic [WW-1:0] MaxW   = WW'(MAX_WIDTH);
    localparam logic [CW-1:0] LastCol = CW'(MAX_WIDTH - 1);

    // configuration and row tracking
    logic [sce_pkg::WIDTH_W-1:0] r_width;
    logic [CW-1:0]               r_col;
    logic                        r_first;

    // line buffer
    logic [sce_pkg::COST_W-1:0]  r_mem [MAX_WIDTH];
    logic [sce_pkg::COST_W-1:0]  r_rd_above;
    logic [sce_pkg::COST_W-1:0]  r_rd_right;
    logic                        r_fwd_above;
    logic                        r_fwd_right;
    logic [sce_pkg::COST_W-1:0]  r_fwd_data;

    // compute stage
    logic                         r_s1_valid;
    logic [sce_pkg::ENERGY_W-1:0] r_s1_energy;
    logic [CW-1:0]                r_s1_col;
    logic                         r_s1_last;
    logic                         r_s1_first;
    logic                         r_s1_top;
    logic [sce_pkg::COST_W-1:0]   r_saved;

    // output register
    logic                        r_out_valid;
    logic [sce_pkg::COST_W-1:0]  r_out_cost;
    logic                        r_out_row_end;

    logic                        in_acc;
    logic                        out_free;
    logic                        s1_adv;
    logic [WW-1:0]               width_ext;
    logic [WW-1:0]               width_eff;
    logic [CW-1:0]               col_in;
    logic                        first_in;
    logic                        last_in;
    logic                        top_in;
    logic [CW-1:0]               rd_addr1;
    logic [CW-1:0]               n_col;
    logic                        n_first;
    logic [sce_pkg::COST_W-1:0]  above;
    logic [sce_pkg::COST_W-1:0]  right;
    logic [sce_pkg::COST_W-1:0]  best;
    logic [sce_pkg::COST_W:0]    sum;
    logic [sce_pkg::COST_W-1:0]  cost;

    assign out_free    = !r_out_valid || o_cost.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_pix.ready = !r_s1_valid || out_free;
    assign in_acc      = i_pix.valid && i_pix.ready;

    always_comb begin
        width_ext = WW'(r_width);
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (width_ext > MaxW) begin
            width_eff = MaxW;
        end else begin
            width_eff = width_ext;
        end
        col_in   = i_pix.frame_start ? '0 : r_col;
        first_in = i_pix.frame_start || r_first;
        last_in  = (WW'(col_in) + WW'(1)) >= width_eff;
        top_in   = (col_in == LastCol);
        rd_addr1 = top_in ? '0 : col_in + CW'(1);
        // wrap on the last pixel of a row; the next row is never a first row
        n_col    = last_in ? '0 : col_in + CW'(1);
        n_first  = last_in ? 1'b0 : first_in;
    end

    always_comb begin
        above = r_fwd_above ? r_fwd_data : r_rd_above;
        right = r_fwd_right ? r_fwd_data : r_rd_right;
        best  = above;
        if (r_s1_col != '0 && r_saved < best) begin
            best = r_saved;
        end
        if (!r_s1_last && !r_s1_top && right < best) begin
            best = right;
        end
        sum = (sce_pkg::COST_W + 1)'(r_s1_energy) + (sce_pkg::COST_W + 1)'(best);
        if (r_s1_first) begin
            cost = sce_pkg::COST_W'(r_s1_energy);
        end else if (sum[sce_pkg::COST_W]) begin
            cost = sce_pkg::COST_SAT;
        end else begin
            cost = sum[sce_pkg::COST_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= sce_pkg::IMAGE_WIDTH_RESET;
            r_col       <= '0;
            r_first     <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_saved     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_width <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_col   <= n_col;
                r_first <= n_first;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_saved     <= above;
            end else if (o_cost.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line buffer: write back on advance, read both neighbors on accept
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_col] <= cost;
        end
        if (in_acc) begin
            r_rd_above  <= r_mem[col_in];
            r_rd_right  <= r_mem[rd_addr1];
            r_fwd_above <= s1_adv && (r_s1_col == col_in);
            r_fwd_right <= s1_adv && (r_s1_col == rd_addr1);
            r_fwd_data  <= cost;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_energy <= i_pix.energy_value;
            r_s1_col    <= col_in;
            r_s1_last   <= last_in;
            r_s1_first  <= first_in;
            r_s1_top    <= top_in;
        end
        if (s1_adv) begin
            r_out_cost    <= cost;
            r_out_row_end <= r_s1_last;
        end
    end

    assign o_cost.valid     = r_out_valid;
    assign o_cost.path_cost = r_out_cost;
    assign o_cost.row_end   = r_out_row_end;

endmodule

FILE: tb/seam_cumulative_energy_unit_tb.sv
`timescale 1ns / 1ps

module seam_cumulative_energy_unit_tb;

    localparam int ENERGY_W     = sce_pkg::ENERGY_W;
    localparam int COST_W       = sce_pkg::COST_W;
    localparam int WIDTH_W      = sce_pkg::WIDTH_W;
    localparam int LINE_DEPTH   = sce_pkg::MAX_WIDTH_DEFAULT;
    localparam int IDX_W        = $clog2(LINE_DEPTH);
    localparam int RANDOM_ITEMS = 1300;
    localparam int SAT_ITEMS    = 280;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 24;

    typedef struct packed {
        logic [COST_W-1:0] path_cost;
        logic              row_end;
    } cost_item_t;

    typedef struct {
        bit                is_cfg;
        bit [WIDTH_W-1:0]  cfg_value;
        bit [ENERGY_W-1:0] energy;
        bit                frame_start;
        bit                typed;
        bit [COST_W-1:0]   cost;
        bit                row_end;
    } stim_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [WIDTH_W-1:0] i_cfg_wr_data;

    sce_energy_if pix_if ();
    sce_cost_if   cost_if ();

    seam_cumulative_energy_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (pix_if),
        .o_cost        (cost_if)
    );

    // predictor state
    bit [COST_W-1:0]  line_costs [LINE_DEPTH];
    int unsigned      col_pos;
    bit               first_row;
    bit [COST_W-1:0]  upper_left;
    bit [WIDTH_W-1:0] width_reg;
    int unsigned      filled_cols;

    cost_item_t pending_costs [$];
    int         error_count;
    int         results_taken;
    int         burst_left;
    bit         quiet_sender;

    // directed stimulus; typed expectations only where they are obvious
    stim_row_t dir_table [DIR_ROWS] = '{
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b1, 16'd255, 1'b0},
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b1, 16'd0,   1'b0},
        '{1'b1, 11'd3,    8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd10,  1'b1, 1'b1, 16'd10,  1'b0},
        '{1'b0, 11'd0,    8'd20,  1'b0, 1'b1, 16'd20,  1'b0},
        '{1'b0, 11'd0,    8'd30,  1'b0, 1'b1, 16'd30,  1'b1},
        '{1'b0, 11'd0,    8'd1,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd2,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd3,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b1, 11'd1,    8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b1, 11'd0,    8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b1, 11'd2047, 8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd128, 1'b1, 1'b1, 16'd128, 1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b1, 16'd255, 1'b0},
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b1, 16'd0,   1'b0},
        '{1'b1, 11'd2,    8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd7,   1'b1, 1'b1, 16'd7,   1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b1, 16'd255, 1'b1},
        '{1'b0, 11'd0,    8'd0,   1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b0, 11'd0,    8'd255, 1'b0, 1'b0, 16'd0,   1'b0},
        '{1'b1, 11'd1024, 8'd0,   1'b0, 1'b0, 16'd0,   1'b0}
    };

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int unsigned eff_width();
        if (width_reg == '0) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return 32'(width_reg);
    endfunction

    function automatic cost_item_t predict_path_cost(bit [ENERGY_W-1:0] energy, bit start);
        cost_item_t      res;
        int unsigned     col;
        int unsigned     sum;
        bit              last;
        bit [COST_W-1:0] above;
        bit [COST_W-1:0] best;
        if (start) begin
            col_pos   = 0;
            first_row = 1'b1;
        end
        col   = col_pos % LINE_DEPTH;
        last  = (col + 1 >= eff_width());
        above = line_costs[IDX_W'(col)];
        if (first_row) begin
            sum = 32'(energy);
        end else begin
            best = above;
            if (col > 0 && upper_left < best) best = upper_left;
            if (!last && col + 1 < LINE_DEPTH && line_costs[IDX_W'(col + 1)] < best)
                best = line_costs[IDX_W'(col + 1)];
            sum = 32'(energy) + 32'(best);
            if (sum > 65535) sum = 65535;
        end
        upper_left               = above;
        line_costs[IDX_W'(col)] = sum[COST_W-1:0];
        if (col + 1 > filled_cols) filled_cols = col + 1;
        if (last) begin
            col_pos   = 0;
            first_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
        res.path_cost = sum[COST_W-1:0];
        res.row_end   = last;
        return res;
    endfunction

    task automatic send_pixel(input bit [ENERGY_W-1:0] energy, input bit start,
                              input bit typed, input cost_item_t typed_res);
        cost_item_t  res;
        int          gap;
        int unsigned col;
        bit          last;
        // restart the image when the next read would touch a never-written column
        col  = col_pos;
        last = (col + 1 >= eff_width());
        if (!start && !first_row && (col >= filled_cols || (!last && col + 1 >= filled_cols)))
            start = 1'b1;
        if (burst_left == 0) begin
            gap = quiet_sender ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        pix_if.valid        <= 1'b1;
        pix_if.energy_value <= energy;
        pix_if.frame_start  <= start;
        do @(posedge i_clk); while (!pix_if.ready);
        res = predict_path_cost(energy, start);
        if (typed) res = typed_res;
        pending_costs = {pending_costs, res};
    endtask

    task automatic set_width(input bit [WIDTH_W-1:0] value);
        pix_if.valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        width_reg = value;
    endtask

    // receiver: random ready pattern, one long hold-off, result checks
    initial begin
        cost_item_t exp_item;
        int         seg_left;
        int         ready_pct;
        bit         held_off;
        seg_left  = 0;
        ready_pct = 100;
        held_off  = 1'b0;
        cost_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (cost_if.valid && cost_if.ready) begin
                results_taken++;
                if (pending_costs.size() == 0) begin
                    $error("unexpected result: path_cost %0d, row_end %0d",
                           cost_if.path_cost, cost_if.row_end);
                    error_count++;
                end else begin
                    exp_item = pending_costs.pop_front();
                    if (cost_if.path_cost !== exp_item.path_cost) begin
                        $error("path_cost: expected %0d, actual %0d",
                               exp_item.path_cost, cost_if.path_cost);
                        error_count++;
                    end
                    if (cost_if.row_end !== exp_item.row_end) begin
                        $error("row_end: expected %0d, actual %0d",
                               exp_item.row_end, cost_if.row_end);
                        error_count++;
                    end
                end
            end
            if (!held_off && results_taken >= HOLD_AT) begin
                // hold off so the pipeline fills and back-pressures the input
                held_off = 1'b1;
                cost_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 120);
                case ($urandom_range(0, 3))
                    0: begin ready_pct = 100; end
                    1: begin ready_pct = 80; end
                    2: begin ready_pct = 50; end
                    default: begin ready_pct = 20; end
                endcase
            end
            seg_left--;
            cost_if.ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        cost_item_t  typed_res;
        int          random_sent;
        int          n;
        int unsigned w;
        int          pick;
        int          emode;
        bit          start_new;
        bit          start;
        bit [ENERGY_W-1:0] energy;

        col_pos       = 0;
        first_row     = 1'b1;
        upper_left    = '0;
        width_reg     = sce_pkg::IMAGE_WIDTH_RESET;
        filled_cols   = 0;
        error_count   = 0;
        results_taken = 0;
        burst_left    = 0;
        quiet_sender  = 1'b0;

        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_wr_data       <= '0;
        pix_if.valid        <= 1'b0;
        pix_if.energy_value <= '0;
        pix_if.frame_start  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_table[k].is_cfg) begin
                set_width(dir_table[k].cfg_value);
            end else begin
                typed_res.path_cost = dir_table[k].cost;
                typed_res.row_end   = dir_table[k].row_end;
                send_pixel(dir_table[k].energy, dir_table[k].frame_start,
                           dir_table[k].typed, typed_res);
            end
        end

        // drive the cost into saturation with one-pixel rows of high energy
        typed_res = '0;
        set_width(11'd1);
        for (int k = 0; k < SAT_ITEMS; k++)
            send_pixel(8'($urandom_range(240, 255)), k == 0, 1'b0, typed_res);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            start_new = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                if (pick < 60)      set_width(11'($urandom_range(1, 8)));
                else if (pick < 85) set_width(11'($urandom_range(9, 64)));
                else if (pick < 90) set_width(11'd0);
                else if (pick < 95) set_width(11'($urandom_range(1025, 2047)));
                else                set_width(11'd1024);
            end
            quiet_sender = ($urandom_range(0, 4) == 0);
            emode = $urandom_range(0, 2);
            w = eff_width();
            if (w > 64) n = $urandom_range(10, 80);
            else        n = w * $urandom_range(1, 5);
            // break some sequences off mid-row or run them into the next row
            if ($urandom_range(0, 4) == 0) n += $urandom_range(0, (w > 64) ? 63 : w - 1);
            if ($urandom_range(0, 9) == 0 && n > 1) n -= $urandom_range(1, n - 1);
            for (int k = 0; k < n; k++) begin
                start = (k == 0 && start_new) || ($urandom_range(0, 99) < 2);
                case (emode)
                    0: begin energy = 8'($urandom_range(0, 255)); end
                    1: begin energy = $urandom_range(0, 1) ? 8'd255 : 8'd0; end
                    default: begin energy = 8'($urandom_range(0, 15)); end
                endcase
                send_pixel(energy, start, 1'b0, typed_res);
                random_sent++;
            end
        end

        pix_if.valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_costs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
